FILE: sv/sles_pkg.sv
// Package with the constants, types and decay table shared by the smoother modules.
package sles_pkg;

	localparam int MAX_STEP_MS = 100;
	localparam int DT_W = $clog2(MAX_STEP_MS + 1);

	localparam int TIME_W = 40;
	localparam int OFFS_W = 24;
	localparam int BUMP_W = 21;
	localparam int SPEED_W = 23;
	localparam int BLEND_W = 16;
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUMP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd1;

	localparam logic [BUMP_W-1:0] MAX_BUMP_RST = 21'd3277;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 23'd65536;

	// Target is (offset * 16 + 50) / 100, done as a reciprocal multiply.
	localparam int TGT_X_W = 28;
	localparam int TGT_Q_W = BUMP_W + 1;
	localparam logic [TGT_X_W-1:0] TGT_BIAS = 28'd50;
	localparam logic [MUL_W-1:0] TGT_RECIP = 32'd343597384;
	localparam int TGT_SHIFT = 35;

	// Limit is (max_speed * dt + 500) / 1000, also by reciprocal multiply.
	localparam int LIM_X_W = 30;
	localparam logic [LIM_X_W-1:0] LIM_BIAS = 30'd500;
	localparam logic [MUL_W-1:0] LIM_RECIP = 32'd1099511628;
	localparam int LIM_SHIFT = 40;

	localparam int FRAC_W = 16;
	localparam logic [PROD_W-1:0] FRAC_HALF = 64'd32768;

	localparam logic [63:0] DECAY_Q32 = 64'd4223977731;

	typedef logic [BLEND_W-1:0] blend_tab_t [0:MAX_STEP_MS];

	function automatic blend_tab_t build_blend_tab();
		logic [63:0] d;
		blend_tab_t t;
		d = 64'd1 << 32;
		for (int k = 0; k <= MAX_STEP_MS; k++) begin
			if (k > 0) begin
				d = (d * DECAY_Q32 + (64'd1 << 31)) >> 32;
			end
			t[k] = BLEND_W'(64'd65536 - ((d + 64'd32768) >> 16));
		end
		return t;
	endfunction

	localparam blend_tab_t BLEND_TAB = build_blend_tab();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_TGT,
		ST_LIM,
		ST_LIMD,
		ST_BLEND,
		ST_UPD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_TGT,
		MUL_LIM,
		MUL_LIMD,
		MUL_BLEND
	} mul_sel_t;

	typedef struct packed {
		logic in_ready;
		logic ld_prep;
		logic ld_tgt;
		logic ld_mag;
		logic ld_lim;
		logic ld_upd;
		logic ld_out;
		logic mul_en;
		mul_sel_t mul_sel;
	} ctrl_t;

endpackage

FILE: sv/sles_mul.sv
// Shared registered multiplier used for every product of the smoother.
module sles_mul
	import sles_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

FILE: sv/sles_fsm.sv
// Sequencer that steps one sample through the shared multiplier.
module sles_fsm
	import sles_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  restart,
	input  logic  slot_free,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = restart ? ST_DONE : ST_TGT;
			end
			ST_TGT:   state_d = ST_LIM;
			ST_LIM:   state_d = ST_LIMD;
			ST_LIMD:  state_d = ST_BLEND;
			ST_BLEND: state_d = ST_UPD;
			ST_UPD:   state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_TGT;
		unique case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_PREP:  ctrl.ld_prep = 1'b1;
			ST_TGT: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_TGT;
			end
			ST_LIM: begin
				ctrl.ld_tgt = 1'b1;
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_LIM;
			end
			ST_LIMD: begin
				ctrl.ld_mag = 1'b1;
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_LIMD;
			end
			ST_BLEND: begin
				ctrl.ld_lim = 1'b1;
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = MUL_BLEND;
			end
			ST_UPD:   ctrl.ld_upd = 1'b1;
			ST_DONE:  ctrl.ld_out = slot_free;
			default:  ctrl.in_ready = 1'b0;
		endcase
	end

endmodule

FILE: sv/slew_limited_exponential_smoother.sv
// Top level of the slew-limited exponential smoother for a camera height offset.
//
// Samples enter on the in channel (in_valid/in_ready) and each one produces exactly
// one result transaction on the out channel (out_valid/out_ready) carrying the
// smoothed offset and the restart flag. Configuration writes use the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data); index 0 is max_bump, index 1 is
// max_speed, other indexes are ignored. cfg_ready is always high, and writes are
// meant to happen only while the block is idle.
// A normal sample steps through the prepare, target, limit, limit divide, blend,
// update and done states of the sequencer before its result is loaded; a restarting
// sample goes from prepare straight to done. The sequencer passes four products
// through one shared 32 by 32 multiplier, one per cycle, plus the decision and
// update steps.
// in_ready is high only while the sequencer is idle. A finished result waits in
// the output register, so the next sample may be taken while the receiver stalls;
// the following result is held in the sequencer until the register is free.
// Reset clears the smoother state so the first sample restarts at offset zero,
// and loads max_bump with 3277 and max_speed with 65536.
module slew_limited_exponential_smoother
	import sles_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [TIME_W-1:0] time_ms,
	input  logic                  on_main_line,
	input  logic                  rough_terrain,
	input  logic                  offset_valid,
	input  logic signed [OFFS_W-1:0] surface_offset,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BUMP_W-1:0]     smoothed_offset,
	output logic                  restarted,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_t ctrl;

	logic [BUMP_W-1:0]   max_bump_q;
	logic [SPEED_W-1:0]  max_speed_q;
	logic                started_q;
	logic [TIME_W-1:0]   last_time_q;
	logic [BUMP_W-1:0]   cur_q;

	logic [TIME_W-1:0]   now_q;
	logic                tgt_en_q;
	logic [OFFS_W-2:0]   offs_q;
	logic [DT_W-1:0]     dt_q;
	logic                rst_flag_q;
	logic [BUMP_W-1:0]   target_q;
	logic [BUMP_W-1:0]   mag_q;
	logic                neg_q;
	logic [BUMP_W-1:0]   limit_q;

	logic                out_valid_q;
	logic [BUMP_W-1:0]   out_offset_q;
	logic                out_rst_q;

	logic                slot_free;
	logic                restart;
	logic [TIME_W-1:0]   elapsed;
	logic [DT_W-1:0]     dt_next;
	logic [TGT_X_W-1:0]  tgt_x;
	logic [LIM_X_W-1:0]  lim_x;
	logic [TGT_Q_W-1:0]  tgt_quot;
	logic [BUMP_W-1:0]   target_d;
	logic [PROD_W-1:0]   rounded;
	logic [BUMP_W-1:0]   step_mag;
	logic [BUMP_W-1:0]   step_lim;
	logic signed [BUMP_W+1:0] sum;
	logic [BUMP_W-1:0]   cur_d;
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   prod;

	assign cfg_ready = 1'b1;
	assign in_ready = ctrl.in_ready;
	assign slot_free = !out_valid_q || out_ready;

	sles_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.restart   (restart),
		.slot_free (slot_free),
		.ctrl      (ctrl)
	);

	sles_mul u_mul (
		.clk  (clk),
		.en   (ctrl.mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bump_q <= MAX_BUMP_RST;
			max_speed_q <= MAX_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_BUMP:  max_bump_q <= cfg_data[BUMP_W-1:0];
				CFG_MAX_SPEED: max_speed_q <= cfg_data[SPEED_W-1:0];
				default:       max_bump_q <= max_bump_q;
			endcase
		end
	end

	assign restart = !started_q || (now_q < last_time_q);
	assign elapsed = now_q - last_time_q;
	assign dt_next = (elapsed > TIME_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS)
	                                                  : elapsed[DT_W-1:0];

	assign tgt_x = {1'b0, offs_q, 4'b0000} + TGT_BIAS;
	assign lim_x = prod[LIM_X_W-1:0] + LIM_BIAS;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.mul_sel)
			MUL_TGT: begin
				mul_a = MUL_W'(tgt_x);
				mul_b = TGT_RECIP;
			end
			MUL_LIM: begin
				mul_a = MUL_W'(max_speed_q);
				mul_b = MUL_W'(dt_q);
			end
			MUL_LIMD: begin
				mul_a = MUL_W'(lim_x);
				mul_b = LIM_RECIP;
			end
			MUL_BLEND: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(BLEND_TAB[dt_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign tgt_quot = prod[TGT_SHIFT +: TGT_Q_W];
	always_comb begin
		if (!tgt_en_q) begin
			target_d = '0;
		end else if (tgt_quot > TGT_Q_W'(max_bump_q)) begin
			target_d = max_bump_q;
		end else begin
			target_d = tgt_quot[BUMP_W-1:0];
		end
	end

	assign rounded = prod + FRAC_HALF;
	assign step_mag = rounded[FRAC_W +: BUMP_W];
	assign step_lim = (step_mag > limit_q) ? limit_q : step_mag;
	assign sum = neg_q ? ($signed({2'b00, cur_q}) - $signed({2'b00, step_lim}))
	                   : ($signed({2'b00, cur_q}) + $signed({2'b00, step_lim}));

	always_comb begin
		if (sum[BUMP_W+1]) begin
			cur_d = '0;
		end else if (sum[BUMP_W:0] > {1'b0, max_bump_q}) begin
			cur_d = max_bump_q;
		end else begin
			cur_d = sum[BUMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			last_time_q <= '0;
			cur_q <= '0;
		end else if (ctrl.ld_prep) begin
			started_q <= 1'b1;
			last_time_q <= now_q;
			if (restart) cur_q <= '0;
		end else if (ctrl.ld_upd) begin
			cur_q <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_q <= time_ms[TIME_W-1] ? '0 : time_ms;
			tgt_en_q <= on_main_line && rough_terrain && offset_valid
			            && !surface_offset[OFFS_W-1];
			offs_q <= surface_offset[OFFS_W-2:0];
		end
		if (ctrl.ld_prep) begin
			rst_flag_q <= restart;
			dt_q <= dt_next;
		end
		if (ctrl.ld_tgt) begin
			target_q <= target_d;
		end
		if (ctrl.ld_mag) begin
			neg_q <= target_q < cur_q;
			mag_q <= (target_q < cur_q) ? (cur_q - target_q) : (target_q - cur_q);
		end
		if (ctrl.ld_lim) begin
			limit_q <= prod[LIM_SHIFT +: BUMP_W];
		end
		if (ctrl.ld_out) begin
			out_offset_q <= cur_q;
			out_rst_q <= rst_flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign smoothed_offset = out_offset_q;
	assign restarted = out_rst_q;

	// A transaction on the input moves the sequencer out of its idle state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer still idle after an input transaction");

	// A restarting result always reports a zero offset.
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restarted |-> smoothed_offset == '0)
		else $error("restart result with nonzero offset");

	// Once started, the smoother only leaves that state through reset.
	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("started flag cleared without reset");

	// The output register is only loaded when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ld_out |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken result");

endmodule
